/* rtl/pauli_frame_propagator_macros.svh */
// Assertion macros shared by the Pauli frame propagator modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PAULI_FRAME_PROPAGATOR_MACROS_SVH
`define PAULI_FRAME_PROPAGATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define PFP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pfp_pkg.sv */
// Shared types, codes and helpers for the Pauli frame propagator.
// No dependencies; imported by every module of the block.
package pfp_pkg;

	localparam int IDX_W       = 6;
	localparam int IDX_SPAN    = 1 << IDX_W;
	localparam int CFG_W       = 7;
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic CFG_NUM_QUBITS = 1'b0;
	localparam logic CFG_NUM_CLBITS = 1'b1;

	typedef enum logic [3:0] {
		OP_CLEAR   = 4'd0,
		OP_H       = 4'd1,
		OP_S       = 4'd2,
		OP_PAULI   = 4'd3,
		OP_QRST    = 4'd4,
		OP_MEAS    = 4'd5,
		OP_CX      = 4'd6,
		OP_FENCE   = 4'd7,
		OP_READ_Q  = 4'd8,
		OP_READ_C  = 4'd9
	} op_t;

	// Work the back end carries out
	typedef enum logic [3:0] {
		ACT_CLEAR,
		ACT_H,
		ACT_S,
		ACT_PAULI,
		ACT_RESET,
		ACT_MEASURE,
		ACT_CX,
		ACT_READ_Q,
		ACT_READ_C,
		ACT_ERROR
	} act_t;

	typedef enum logic [1:0] {
		FLT_NONE = 2'd0,
		FLT_X    = 2'd1,
		FLT_Y    = 2'd2,
		FLT_Z    = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		KIND_MEAS   = 2'd0,
		KIND_READ_Q = 2'd1,
		KIND_READ_C = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_QUBIT = 2'd1,
		ST_CLBIT = 2'd2
	} status_t;

	// Classified item, front to back
	typedef struct packed {
		act_t               act;
		logic [IDX_W-1:0]   qa;
		logic [IDX_W-1:0]   qb;
		logic [IDX_W-1:0]   cb;
		fault_t             fa;
		fault_t             fb;
		kind_t              err_kind;
		logic [IDX_W-1:0]   err_index;
		status_t            err_status;
	} cmd_t;

	// One result item
	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   index;
		logic               x_bit;
		logic               z_bit;
		status_t            status;
	} res_t;

	// Queue handshake, front to queue
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	function automatic logic fault_x(input fault_t f);
		return (f == FLT_X) || (f == FLT_Y);
	endfunction

	function automatic logic fault_z(input fault_t f);
		return (f == FLT_Y) || (f == FLT_Z);
	endfunction

endpackage

/* rtl/pfp_front.sv */
// Front end: configuration registers, range checks and op decoding.
// Depends on pfp_pkg; feeds pfp_queue.
module pfp_front #(
	parameter int MAX_QUBITS = 64,
	parameter int MAX_CLBITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        q_ready,
	input  logic [3:0]                  op,
	input  logic [pfp_pkg::IDX_W-1:0]   qubit_a,
	input  logic [pfp_pkg::IDX_W-1:0]   qubit_b,
	input  logic [pfp_pkg::IDX_W-1:0]   clbit_index,
	input  pfp_pkg::fault_t             fault_a,
	input  pfp_pkg::fault_t             fault_b,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [pfp_pkg::CFG_W-1:0]   cfg_data,
	output pfp_pkg::push_t              push
);
	import pfp_pkg::*;

	logic [CFG_W-1:0] num_qubits_q;
	logic [CFG_W-1:0] num_clbits_q;
	logic             qa_ok, qb_ok, cb_ok;
	logic             keep;
	cmd_t             cmd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_qubits_q <= CFG_W'(IDX_SPAN);
			num_clbits_q <= CFG_W'(IDX_SPAN);
		end else if (cfg_we) begin
			if (cfg_index == CFG_NUM_QUBITS) num_qubits_q <= cfg_data;
			if (cfg_index == CFG_NUM_CLBITS) num_clbits_q <= cfg_data;
		end
	end

	// Range checks against the configured and the built-in limits
	assign qa_ok = ({1'b0, qubit_a} < num_qubits_q) && (32'(qubit_a) < MAX_QUBITS);
	assign qb_ok = ({1'b0, qubit_b} < num_qubits_q) && (32'(qubit_b) < MAX_QUBITS);
	assign cb_ok = ({1'b0, clbit_index} < num_clbits_q) && (32'(clbit_index) < MAX_CLBITS);

	// Decode; range errors are settled here and carried as their own action
	always_comb begin
		cmd            = '0;
		cmd.qa         = qubit_a;
		cmd.qb         = qubit_b;
		cmd.cb         = clbit_index;
		cmd.fa         = fault_a;
		cmd.fb         = fault_b;
		cmd.act        = ACT_CLEAR;
		cmd.err_kind   = KIND_READ_Q;
		cmd.err_index  = qubit_a;
		cmd.err_status = ST_QUBIT;
		keep           = 1'b1;
		unique case (op_t'(op))
			OP_CLEAR: begin
				cmd.act = ACT_CLEAR;
			end
			OP_H, OP_S, OP_PAULI, OP_QRST: begin
				case (op_t'(op))
					OP_H:    cmd.act = ACT_H;
					OP_S:    cmd.act = ACT_S;
					OP_PAULI: cmd.act = ACT_PAULI;
					default: cmd.act = ACT_RESET;
				endcase
				if (!qa_ok) cmd.act = ACT_ERROR;
			end
			OP_MEAS: begin
				cmd.act      = ACT_MEASURE;
				cmd.err_kind = KIND_MEAS;
				if (!qa_ok) begin
					cmd.act = ACT_ERROR;
				end else if (!cb_ok) begin
					cmd.act        = ACT_ERROR;
					cmd.err_index  = clbit_index;
					cmd.err_status = ST_CLBIT;
				end
			end
			OP_CX: begin
				cmd.act = ACT_CX;
				if (!qa_ok) begin
					cmd.act = ACT_ERROR;
				end else if (!qb_ok) begin
					cmd.act       = ACT_ERROR;
					cmd.err_index = qubit_b;
				end
			end
			OP_READ_Q: begin
				cmd.act = qa_ok ? ACT_READ_Q : ACT_ERROR;
			end
			OP_READ_C: begin
				cmd.act        = cb_ok ? ACT_READ_C : ACT_ERROR;
				cmd.err_kind   = KIND_READ_C;
				cmd.err_index  = clbit_index;
				cmd.err_status = ST_CLBIT;
			end
			OP_FENCE: begin
				keep = 1'b0;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Barriers and unused codes are taken but leave no trace
	assign push.push = in_valid && q_ready && keep;
	assign push.cmd  = cmd;

endmodule

/* rtl/pfp_queue.sv */
// Short queue of classified items between front and back end.
// Depends on pfp_pkg and the assertion macro header.
`include "pauli_frame_propagator_macros.svh"
module pfp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  pfp_pkg::push_t  push,
	output logic            ready,
	input  logic            pop,
	output logic            valid,
	output pfp_pkg::cmd_t   head
);
	import pfp_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign ready = (count_q != FULL_CNT);
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)       rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push.push && !pop)      count_q <= count_q + CW'(1);
			else if (!push.push && pop) count_q <= count_q - CW'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push.push) entry_q[wr_ptr_q] <= push.cmd;
	end

	`PFP_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT, "queue overfilled")
	`PFP_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, count_q != '0, "pop from empty queue")
	`PFP_ASSERT_NXT(a_push_grows, clk, arst_n, push.push && !pop,
		count_q == $past(count_q) + CW'(1), "queue count did not grow")

endmodule

/* rtl/pfp_back.sv */
// Back end: Pauli frame and measured bits, gate execution, result register.
// Depends on pfp_pkg and the assertion macro header; fed by pfp_queue.
`include "pauli_frame_propagator_macros.svh"
module pfp_back #(
	parameter int MAX_QUBITS = 64,
	parameter int MAX_CLBITS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  pfp_pkg::cmd_t   cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output pfp_pkg::res_t   res
);
	import pfp_pkg::*;

	localparam int QCAP = (MAX_QUBITS < IDX_SPAN) ? MAX_QUBITS : IDX_SPAN;
	localparam int CCAP = (MAX_CLBITS < IDX_SPAN) ? MAX_CLBITS : IDX_SPAN;
	localparam int QIW  = (QCAP > 1) ? $clog2(QCAP) : 1;
	localparam int CIW  = (CCAP > 1) ? $clog2(CCAP) : 1;
	localparam int QFW  = 1 << QIW;
	localparam int CFW  = 1 << CIW;

	logic [QFW-1:0] x_q, z_q, x_d, z_d;
	logic [CFW-1:0] m_q, m_d;
	logic [QIW-1:0] a, b;
	logic [CIW-1:0] c;
	logic           xa, za, xb, zb, fxa, fza, fxb, fzb, meas_v;
	logic           res_vld;
	logic           out_valid_q;
	res_t           res_d, res_q;

	// Out of range indexes never reach here, so the low bits suffice
	assign a   = cmd.qa[QIW-1:0];
	assign b   = cmd.qb[QIW-1:0];
	assign c   = cmd.cb[CIW-1:0];
	assign xa  = x_q[a];
	assign za  = z_q[a];
	assign xb  = x_q[b];
	assign zb  = z_q[b];
	assign fxa = fault_x(cmd.fa);
	assign fza = fault_z(cmd.fa);
	assign fxb = fault_x(cmd.fb);
	assign fzb = fault_z(cmd.fb);
	assign meas_v = xa ^ fxa;

	// Result register takes a new item whenever it is empty or being drained
	assign pop = cmd_valid && (!out_valid_q || out_ready);

	// Frame update and result for the item at the head of the queue
	always_comb begin
		x_d     = x_q;
		z_d     = z_q;
		m_d     = m_q;
		res_vld = 1'b0;
		res_d   = '0;
		case (cmd.act)
			ACT_CLEAR: begin
				x_d = '0;
				z_d = '0;
				m_d = '0;
			end
			ACT_H: begin
				x_d[a] = za ^ fxa;
				z_d[a] = xa ^ fza;
			end
			ACT_S: begin
				x_d[a] = xa ^ fxa;
				z_d[a] = za ^ xa ^ fza;
			end
			ACT_PAULI: begin
				x_d[a] = xa ^ fxa;
				z_d[a] = za ^ fza;
			end
			ACT_RESET: begin
				x_d[a] = fxa;
				z_d[a] = fza;
			end
			ACT_MEASURE: begin
				x_d[a]       = meas_v;
				z_d[a]       = za ^ fza;
				m_d[c]       = meas_v;
				res_vld      = 1'b1;
				res_d.kind   = KIND_MEAS;
				res_d.index  = cmd.cb;
				res_d.x_bit  = meas_v;
				res_d.status = ST_OK;
			end
			ACT_CX: begin
				// sequenced so that a control equal to its target clears the qubit
				x_d[b] = xb ^ xa;
				z_d[a] = za ^ zb;
				x_d[a] = x_d[a] ^ fxa;
				z_d[a] = z_d[a] ^ fza;
				x_d[b] = x_d[b] ^ fxb;
				z_d[b] = z_d[b] ^ fzb;
			end
			ACT_READ_Q: begin
				res_vld      = 1'b1;
				res_d.kind   = KIND_READ_Q;
				res_d.index  = cmd.qa;
				res_d.x_bit  = xa;
				res_d.z_bit  = za;
				res_d.status = ST_OK;
			end
			ACT_READ_C: begin
				res_vld      = 1'b1;
				res_d.kind   = KIND_READ_C;
				res_d.index  = cmd.cb;
				res_d.x_bit  = m_q[c];
				res_d.status = ST_OK;
			end
			ACT_ERROR: begin
				res_vld      = 1'b1;
				res_d.kind   = cmd.err_kind;
				res_d.index  = cmd.err_index;
				res_d.status = cmd.err_status;
			end
			default: begin
				res_vld = 1'b0;
			end
		endcase
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			z_q <= '0;
			m_q <= '0;
		end else if (pop) begin
			x_q <= x_d;
			z_q <= z_d;
			m_q <= m_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= res_vld;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop && res_vld) res_q <= res_d;
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	`PFP_ASSERT_IMP(a_no_pop_when_stalled, clk, arst_n, out_valid_q && !out_ready, !pop,
		"item taken while result stalled")
	`PFP_ASSERT_NXT(a_result_follows_pop, clk, arst_n, pop && res_vld, out_valid_q,
		"result lost after execution")

endmodule

/* rtl/pauli_frame_propagator.sv */
// Pauli frame propagator: an accepted item enters the queue; when the back end takes it,
// its result is registered and shows on m_tvalid in the cycle after that.
// Throughput 1 item per cycle unless m_tready stalls the result, set by the read-modify-write
// of the frame registers in the back end; a 4-item queue decouples decoding from execution.
// Reset (arst_n low, asynchronous) clears the frame, the measured bits and all control
// state and sets both size registers to 64; s_tready is high from release on until the queue fills.
module pauli_frame_propagator #(
	parameter int MAX_QUBITS = 64,
	parameter int MAX_CLBITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // op[3:0], qubit_a[9:4], qubit_b[15:10],
	                               // clbit_index[21:16], fault_a[23:22], fault_b[25:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // index[5:0], x_bit[6], z_bit[7], status[9:8]
	output logic [1:0]  m_tuser,   // kind[1:0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	import pfp_pkg::*;

	push_t push;
	logic  q_ready, q_valid, pop;
	cmd_t  head;
	res_t  res;

	pfp_front #(
		.MAX_QUBITS (MAX_QUBITS),
		.MAX_CLBITS (MAX_CLBITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.q_ready     (q_ready),
		.op          (s_tdata[3:0]),
		.qubit_a     (s_tdata[9:4]),
		.qubit_b     (s_tdata[15:10]),
		.clbit_index (s_tdata[21:16]),
		.fault_a     (fault_t'(s_tdata[23:22])),
		.fault_b     (fault_t'(s_tdata[25:24])),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push)
	);

	pfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ready  (q_ready),
		.pop    (pop),
		.valid  (q_valid),
		.head   (head)
	);

	pfp_back #(
		.MAX_QUBITS (MAX_QUBITS),
		.MAX_CLBITS (MAX_CLBITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res)
	);

	assign s_tready = q_ready;
	assign m_tdata  = {6'd0, res.status, res.z_bit, res.x_bit, res.index};
	assign m_tuser  = res.kind;

endmodule
